// File: rtl/afpm_pkg.sv
// Shared constants, command types and state encodings of the attitude filter and PD mixer.
`timescale 1ns / 1ps

package afpm_pkg;

    // Fixed-point format of the angle estimates and drive saturation.
    localparam int ANGLE_FRAC_BITS = 8;
    localparam int DUTY_MAX        = 4000;

    // Intermediate format is degrees times 2^IFRAC.
    localparam int IFRAC    = 24;
    localparam int UP_SH    = IFRAC - ANGLE_FRAC_BITS;
    localparam int BLEND_SH = 2 * IFRAC - ANGLE_FRAC_BITS;

    // Field widths.
    localparam int SAMP_W  = 16;
    localparam int DIFF_W  = SAMP_W + 1;
    localparam int COLL_W  = 8;
    localparam int SP_W    = 9;
    localparam int DRV_W   = 12;
    localparam int ANGLE_W = 17;
    localparam int YT_W    = 9;

    // Stream and configuration port widths.
    localparam int IN_W   = 112;
    localparam int OUT_W  = 104;
    localparam int CFG_AW = 3;
    localparam int CFG_DW = 16;

    // Datapath widths.
    localparam int PRE_W   = ANGLE_W + UP_SH + 2;
    localparam int MUL_A_W = PRE_W + 1;
    localparam int MUL_B_W = 25;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int SUM_W   = PRE_W + IFRAC;
    localparam int RND_W   = SUM_W - BLEND_SH;
    localparam int YRAW_W  = ANGLE_W + 2;
    localparam int ERR_W   = ANGLE_W + 2;
    localparam int MIX_W   = 44;
    localparam int KSUM_W  = 16;
    localparam int N_MOTOR = 4;

    // Scale factors in the intermediate format.
    localparam int RATE_DT_K = 1023;
    localparam int ACC_K     = 92160;
    localparam int W_NEW     = 33554;
    localparam int D_RP_K    = 8 * 511500;
    localparam int D_YAW_K   = 5 * 511500;
    localparam int P_RP_K    = 10 << UP_SH;
    localparam int P_YAW_K   = 15 << UP_SH;
    localparam int COLL_K    = 20;
    localparam int DRIVE_MIN = 1200;

    // Angle limits with ANGLE_FRAC_BITS fraction bits.
    localparam int ANG_LIM          = 180 << ANGLE_FRAC_BITS;
    localparam int ANG_FULL         = 360 << ANGLE_FRAC_BITS;
    localparam int YAW_RESET        = 280 << ANGLE_FRAC_BITS;
    localparam int YAW_TARGET_RESET = 280;
    localparam int YAW_HALF         = 1 << (UP_SH - 1);

    localparam logic signed [SUM_W-1:0] SUM_HALF = SUM_W'(1) <<< (BLEND_SH - 1);

    // Motors whose drive takes each axis term with a minus sign (bit 0 is motor 1).
    localparam logic [N_MOTOR-1:0] NEG_ROLL  = 4'b1100;
    localparam logic [N_MOTOR-1:0] NEG_PITCH = 4'b1001;
    localparam logic [N_MOTOR-1:0] NEG_YAW   = 4'b1010;

    typedef enum logic [CFG_AW-1:0] {
        REG_ROLL_ZERO  = 3'd0,
        REG_PITCH_ZERO = 3'd1,
        REG_GX_ZERO    = 3'd2,
        REG_GY_ZERO    = 3'd3,
        REG_GZ_ZERO    = 3'd4,
        REG_YAW_TARGET = 3'd5
    } cfg_idx_t;

    typedef enum logic [3:0] {
        MUL_NONE,
        MUL_RDT_R,
        MUL_RDT_P,
        MUL_RDT_Y,
        MUL_ACC_R,
        MUL_ACC_P,
        MUL_BL_R,
        MUL_BL_P,
        MUL_DR,
        MUL_DP,
        MUL_YD,
        MUL_PR,
        MUL_PP,
        MUL_YE
    } mul_op_t;

    typedef enum logic [3:0] {
        ACC_NONE,
        ACC_PRE_R,
        ACC_PRE_P,
        ACC_YAW_RND,
        ACC_DIFF_R,
        ACC_DIFF_P,
        ACC_SUM_R,
        ACC_SUM_P,
        ACC_MIX_R,
        ACC_MIX_P,
        ACC_MIX_Y
    } acc_op_t;

    typedef enum logic [2:0] {
        AUX_NONE,
        AUX_MIX_INIT,
        AUX_YAW_WRAP,
        AUX_YAW_ERR,
        AUX_RND_R,
        AUX_RND_P,
        AUX_OUT
    } aux_op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RDT_R,
        ST_RDT_P,
        ST_RDT_Y,
        ST_ACC_R,
        ST_ACC_P,
        ST_BL_R,
        ST_BL_P,
        ST_DR,
        ST_DP,
        ST_YD,
        ST_PR,
        ST_PP,
        ST_YE,
        ST_LAST,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic    load;
        mul_op_t mul_op;
        acc_op_t acc_op;
        aux_op_t aux_op;
    } cmd_t;

    typedef struct packed {
        logic out_free;
    } sts_t;

endpackage

// File: rtl/afpm_ctrl.sv
// Sequencer that steps the shared multiplier and accumulators through one sample.
`timescale 1ns / 1ps

module afpm_ctrl import afpm_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // No request is taken while reset is held.
    assign s_tready = aresetn && (state_reg == ST_IDLE);

    // A step issues at most one multiply and may consume the previous step's product.
    always_comb begin
        state_next = state_reg;
        cmd = '{load: 1'b0, mul_op: MUL_NONE, acc_op: ACC_NONE, aux_op: AUX_NONE};
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid && s_tready) begin
                    cmd.load   = 1'b1;
                    state_next = ST_RDT_R;
                end
            end
            ST_RDT_R: begin
                cmd.mul_op = MUL_RDT_R;
                cmd.aux_op = AUX_MIX_INIT;
                state_next = ST_RDT_P;
            end
            ST_RDT_P: begin
                cmd.mul_op = MUL_RDT_P;
                cmd.acc_op = ACC_PRE_R;
                state_next = ST_RDT_Y;
            end
            ST_RDT_Y: begin
                cmd.mul_op = MUL_RDT_Y;
                cmd.acc_op = ACC_PRE_P;
                state_next = ST_ACC_R;
            end
            ST_ACC_R: begin
                cmd.mul_op = MUL_ACC_R;
                cmd.acc_op = ACC_YAW_RND;
                state_next = ST_ACC_P;
            end
            ST_ACC_P: begin
                cmd.mul_op = MUL_ACC_P;
                cmd.acc_op = ACC_DIFF_R;
                cmd.aux_op = AUX_YAW_WRAP;
                state_next = ST_BL_R;
            end
            ST_BL_R: begin
                cmd.mul_op = MUL_BL_R;
                cmd.acc_op = ACC_DIFF_P;
                cmd.aux_op = AUX_YAW_ERR;
                state_next = ST_BL_P;
            end
            ST_BL_P: begin
                cmd.mul_op = MUL_BL_P;
                cmd.acc_op = ACC_SUM_R;
                state_next = ST_DR;
            end
            ST_DR: begin
                cmd.mul_op = MUL_DR;
                cmd.acc_op = ACC_SUM_P;
                cmd.aux_op = AUX_RND_R;
                state_next = ST_DP;
            end
            ST_DP: begin
                cmd.mul_op = MUL_DP;
                cmd.acc_op = ACC_MIX_R;
                cmd.aux_op = AUX_RND_P;
                state_next = ST_YD;
            end
            ST_YD: begin
                cmd.mul_op = MUL_YD;
                cmd.acc_op = ACC_MIX_P;
                state_next = ST_PR;
            end
            ST_PR: begin
                cmd.mul_op = MUL_PR;
                cmd.acc_op = ACC_MIX_Y;
                state_next = ST_PP;
            end
            ST_PP: begin
                cmd.mul_op = MUL_PP;
                cmd.acc_op = ACC_MIX_R;
                state_next = ST_YE;
            end
            ST_YE: begin
                cmd.mul_op = MUL_YE;
                cmd.acc_op = ACC_MIX_P;
                state_next = ST_LAST;
            end
            ST_LAST: begin
                cmd.acc_op = ACC_MIX_Y;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (sts.out_free) begin
                    cmd.aux_op = AUX_OUT;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == ST_RDT_R))
        else $error("accepted request did not start the sequence");

    a_out_into_free_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.aux_op == AUX_OUT) |-> sts.out_free)
        else $error("result loaded while the output register is occupied");
`endif

endmodule

// File: rtl/afpm_dp.sv
// Datapath: offset registers, shared multiplier, filter state and motor accumulators.
`timescale 1ns / 1ps

module afpm_dp import afpm_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic [CFG_AW-1:0] cfg_addr,
    input  logic [CFG_DW-1:0] cfg_wdata,
    input  logic [IN_W-1:0]   s_tdata,
    input  logic              m_tready,
    output logic              m_tvalid,
    output logic [OUT_W-1:0]  m_tdata,
    input  cmd_t              cmd,
    output sts_t              sts
);

    // Offset registers.
    logic [SAMP_W-1:0] roll_zero_reg;
    logic [SAMP_W-1:0] pitch_zero_reg;
    logic [SAMP_W-1:0] gx_zero_reg;
    logic [SAMP_W-1:0] gy_zero_reg;
    logic [SAMP_W-1:0] gz_zero_reg;
    logic [YT_W-1:0]   yaw_target_reg;

    // Latched sample, offsets removed.
    logic signed [DIFF_W-1:0] ax_reg;
    logic signed [DIFF_W-1:0] ay_reg;
    logic signed [DIFF_W-1:0] gx_reg;
    logic signed [DIFF_W-1:0] gy_reg;
    logic signed [DIFF_W-1:0] gz_reg;
    logic [COLL_W-1:0]        coll_reg;
    logic signed [SP_W-1:0]   rsp_reg;
    logic signed [SP_W-1:0]   psp_reg;

    // Filter state.
    logic signed [ANGLE_W-1:0] roll_reg;
    logic signed [ANGLE_W-1:0] pitch_reg;
    logic [ANGLE_W-1:0]        yaw_reg;

    // Intermediates.
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [PRE_W-1:0]   pre_r_reg;
    logic signed [PRE_W-1:0]   pre_p_reg;
    logic signed [MUL_A_W-1:0] diff_r_reg;
    logic signed [MUL_A_W-1:0] diff_p_reg;
    logic signed [SUM_W-1:0]   sum_r_reg;
    logic signed [SUM_W-1:0]   sum_p_reg;
    logic signed [PRE_W-1:0]   yaw_sum;
    logic signed [YRAW_W-1:0]  yaw_raw_reg;
    logic signed [ERR_W-1:0]   err_raw;
    logic signed [ERR_W-1:0]   err_reg;
    logic signed [MIX_W-1:0]   mix_reg [N_MOTOR];
    logic signed [MIX_W-1:0]   mix_term;
    logic signed [KSUM_W-1:0]  mix_k [N_MOTOR];
    logic signed [KSUM_W-1:0]  coll_k;
    logic signed [KSUM_W-1:0]  rsp2;
    logic signed [KSUM_W-1:0]  psp2;
    logic [N_MOTOR-1:0]        mix_neg;
    logic                      m_tvalid_reg;
    logic [OUT_W-1:0]          m_tdata_reg;

    function automatic logic signed [ANGLE_W-1:0] round_sat(input logic signed [SUM_W-1:0] s);
        logic signed [SUM_W-1:0] t;
        logic signed [RND_W-1:0] r;
        t = (s + SUM_HALF) >>> BLEND_SH;
        r = RND_W'(t);
        if (r > RND_W'(ANG_LIM)) begin
            return ANGLE_W'(ANG_LIM);
        end else if (r < -RND_W'(ANG_LIM)) begin
            return -ANGLE_W'(ANG_LIM);
        end
        return ANGLE_W'(r);
    endfunction

    function automatic logic [DRV_W-1:0] drive(input logic signed [MIX_W-1:0] m);
        logic signed [MIX_W-1:0] d;
        d = m >>> IFRAC;
        if (m < (MIX_W'(DRIVE_MIN) <<< IFRAC)) begin
            return '0;
        end else if (d > MIX_W'(DUTY_MAX)) begin
            return DRV_W'(DUTY_MAX);
        end
        return DRV_W'(d);
    endfunction

    // Configuration writes; indexes past the list are dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            roll_zero_reg  <= '0;
            pitch_zero_reg <= '0;
            gx_zero_reg    <= '0;
            gy_zero_reg    <= '0;
            gz_zero_reg    <= '0;
            yaw_target_reg <= YT_W'(YAW_TARGET_RESET);
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_ROLL_ZERO:  roll_zero_reg  <= cfg_wdata;
                REG_PITCH_ZERO: pitch_zero_reg <= cfg_wdata;
                REG_GX_ZERO:    gx_zero_reg    <= cfg_wdata;
                REG_GY_ZERO:    gy_zero_reg    <= cfg_wdata;
                REG_GZ_ZERO:    gz_zero_reg    <= cfg_wdata;
                REG_YAW_TARGET: yaw_target_reg <= cfg_wdata[YT_W-1:0];
                default: ;
            endcase
        end
    end

    // Sample capture with offsets removed; the gyro y axis is negated here.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            ax_reg   <= {s_tdata[15], s_tdata[15:0]} - {roll_zero_reg[15], roll_zero_reg};
            ay_reg   <= {s_tdata[31], s_tdata[31:16]} - {pitch_zero_reg[15], pitch_zero_reg};
            gx_reg   <= {s_tdata[47], s_tdata[47:32]} - {gx_zero_reg[15], gx_zero_reg};
            gy_reg   <= {gy_zero_reg[15], gy_zero_reg} - {s_tdata[63], s_tdata[63:48]};
            gz_reg   <= {s_tdata[79], s_tdata[79:64]} - {gz_zero_reg[15], gz_zero_reg};
            coll_reg <= s_tdata[87:80];
            rsp_reg  <= s_tdata[96:88];
            psp_reg  <= s_tdata[105:97];
        end
    end

    // Shared multiplier operand selection.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.mul_op)
            MUL_RDT_R: begin mul_a = MUL_A_W'(gy_reg);     mul_b = MUL_B_W'(RATE_DT_K); end
            MUL_RDT_P: begin mul_a = MUL_A_W'(gx_reg);     mul_b = MUL_B_W'(RATE_DT_K); end
            MUL_RDT_Y: begin mul_a = MUL_A_W'(gz_reg);     mul_b = MUL_B_W'(RATE_DT_K); end
            MUL_ACC_R: begin mul_a = MUL_A_W'(ax_reg);     mul_b = MUL_B_W'(ACC_K);     end
            MUL_ACC_P: begin mul_a = MUL_A_W'(ay_reg);     mul_b = MUL_B_W'(ACC_K);     end
            MUL_BL_R:  begin mul_a = diff_r_reg;           mul_b = MUL_B_W'(W_NEW);     end
            MUL_BL_P:  begin mul_a = diff_p_reg;           mul_b = MUL_B_W'(W_NEW);     end
            MUL_DR:    begin mul_a = MUL_A_W'(gy_reg);     mul_b = MUL_B_W'(D_RP_K);    end
            MUL_DP:    begin mul_a = MUL_A_W'(gx_reg);     mul_b = MUL_B_W'(D_RP_K);    end
            MUL_YD:    begin mul_a = MUL_A_W'(gz_reg);     mul_b = MUL_B_W'(D_YAW_K);   end
            MUL_PR:    begin mul_a = MUL_A_W'(roll_reg);   mul_b = MUL_B_W'(P_RP_K);    end
            MUL_PP:    begin mul_a = MUL_A_W'(pitch_reg);  mul_b = MUL_B_W'(P_RP_K);    end
            MUL_YE:    begin mul_a = MUL_A_W'(err_reg);    mul_b = MUL_B_W'(P_YAW_K);   end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
    end

    // Yaw integration: old yaw in Q24 with the rounding half folded in, plus rate times dt.
    assign yaw_sum = ((PRE_W'($signed({1'b0, yaw_reg})) <<< UP_SH) | PRE_W'(YAW_HALF))
                     + PRE_W'(prod_reg);

    assign err_raw = ERR_W'($signed({1'b0, yaw_reg}))
                     - (ERR_W'($signed({1'b0, yaw_target_reg})) <<< ANGLE_FRAC_BITS);

    // Product consumers.
    always_ff @(posedge aclk) begin
        case (cmd.acc_op)
            ACC_PRE_R:   pre_r_reg   <= (PRE_W'(roll_reg) <<< UP_SH) + PRE_W'(prod_reg);
            ACC_PRE_P:   pre_p_reg   <= (PRE_W'(pitch_reg) <<< UP_SH) + PRE_W'(prod_reg);
            ACC_YAW_RND: yaw_raw_reg <= YRAW_W'(yaw_sum >>> UP_SH);
            ACC_DIFF_R:  diff_r_reg  <= MUL_A_W'(prod_reg) - MUL_A_W'(pre_r_reg);
            ACC_DIFF_P:  diff_p_reg  <= MUL_A_W'(prod_reg) - MUL_A_W'(pre_p_reg);
            ACC_SUM_R:   sum_r_reg   <= (SUM_W'(pre_r_reg) <<< IFRAC) + SUM_W'(prod_reg);
            ACC_SUM_P:   sum_p_reg   <= (SUM_W'(pre_p_reg) <<< IFRAC) + SUM_W'(prod_reg);
            default: ;
        endcase
        if (cmd.aux_op == AUX_YAW_ERR) begin
            if (err_raw < -ERR_W'(ANG_LIM)) begin
                err_reg <= err_raw + ERR_W'(ANG_FULL);
            end else if (err_raw > ERR_W'(ANG_LIM)) begin
                err_reg <= err_raw - ERR_W'(ANG_FULL);
            end else begin
                err_reg <= err_raw;
            end
        end
    end

    // Filter state; one wrap correction per sample for yaw.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            roll_reg  <= '0;
            pitch_reg <= '0;
            yaw_reg   <= ANGLE_W'(YAW_RESET);
        end else begin
            case (cmd.aux_op)
                AUX_RND_R: roll_reg  <= round_sat(sum_r_reg);
                AUX_RND_P: pitch_reg <= round_sat(sum_p_reg);
                AUX_YAW_WRAP: begin
                    if (yaw_raw_reg >= YRAW_W'(ANG_FULL)) begin
                        yaw_reg <= ANGLE_W'(yaw_raw_reg - YRAW_W'(ANG_FULL));
                    end else if (yaw_raw_reg < 0) begin
                        yaw_reg <= ANGLE_W'(yaw_raw_reg + YRAW_W'(ANG_FULL));
                    end else begin
                        yaw_reg <= ANGLE_W'(yaw_raw_reg);
                    end
                end
                default: ;
            endcase
        end
    end

    // Motor mixer: each lane starts from throttle and setpoint terms, then takes axis terms.
    assign coll_k   = KSUM_W'($signed({1'b0, coll_reg})) * KSUM_W'(COLL_K);
    assign rsp2     = KSUM_W'(rsp_reg) <<< 1;
    assign psp2     = KSUM_W'(psp_reg) <<< 1;
    assign mix_term = MIX_W'(prod_reg);

    always_comb begin
        for (int m = 0; m < N_MOTOR; m++) begin
            mix_k[m] = coll_k + (NEG_ROLL[m] ? rsp2 : -rsp2) + (NEG_PITCH[m] ? psp2 : -psp2);
        end
        case (cmd.acc_op)
            ACC_MIX_R: mix_neg = NEG_ROLL;
            ACC_MIX_P: mix_neg = NEG_PITCH;
            default:   mix_neg = NEG_YAW;
        endcase
    end

    always_ff @(posedge aclk) begin
        for (int m = 0; m < N_MOTOR; m++) begin
            if (cmd.aux_op == AUX_MIX_INIT) begin
                mix_reg[m] <= MIX_W'(mix_k[m]) <<< IFRAC;
            end else if (cmd.acc_op == ACC_MIX_R || cmd.acc_op == ACC_MIX_P
                         || cmd.acc_op == ACC_MIX_Y) begin
                mix_reg[m] <= mix_neg[m] ? mix_reg[m] - mix_term : mix_reg[m] + mix_term;
            end
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.aux_op == AUX_OUT) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.aux_op == AUX_OUT) begin
            m_tdata_reg <= {5'b0, yaw_reg, pitch_reg, roll_reg,
                            drive(mix_reg[3]), drive(mix_reg[2]),
                            drive(mix_reg[1]), drive(mix_reg[0])};
        end
    end

    assign m_tvalid     = m_tvalid_reg;
    assign m_tdata      = m_tdata_reg;
    assign sts.out_free = !m_tvalid_reg || m_tready;

`ifndef SYNTHESIS
    a_roll_pitch_limited: assert property (@(posedge aclk) disable iff (!aresetn)
        (roll_reg <= ANGLE_W'(ANG_LIM)) && (roll_reg >= -ANGLE_W'(ANG_LIM))
        && (pitch_reg <= ANGLE_W'(ANG_LIM)) && (pitch_reg >= -ANGLE_W'(ANG_LIM)))
        else $error("roll or pitch estimate beyond saturation limit");

    a_yaw_wrapped: assert property (@(posedge aclk) disable iff (!aresetn)
        yaw_reg < ANGLE_W'(ANG_FULL))
        else $error("yaw estimate not wrapped into one turn");

    a_out_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.aux_op == AUX_OUT) |=> m_tvalid)
        else $error("result load did not raise the output valid");
`endif

endmodule

// File: rtl/attitude_filter_pd_mixer_top.sv
// Top level of the attitude filter and PD quadrotor mixer.
`timescale 1ns / 1ps

// Usage:
// One request on the s_ channel carries one IMU sample (two accelerometer axes, three
// gyro axes) and the pilot command (collective, roll and pitch setpoints). For each
// request the block returns exactly one result on the m_ channel: four motor drives
// and the updated roll, pitch and yaw estimates.
// The user must write the offset registers and yaw target via cfg_wr_en, cfg_addr and
// cfg_wdata only while the block is idle; the block does not enforce this. Indexes
// past the register list are dropped.
// Timing: a request is taken only while the sequencer is idle, so a new request waits
// until the previous result has been loaded into the output register. The sequencer
// steps one shared 36 x 25 bit multiplier through thirteen products, one per cycle.
// The result sits in an output register; a stalled receiver does not block the next
// request, which is processed up to the final step and waits there until the previous
// result has been taken.
// Reset (aresetn low, synchronous) clears roll and pitch to zero, sets yaw to 280
// degrees, zeroes the offsets, sets the yaw target to 280 and drops any pending result.

module attitude_filter_pd_mixer_top import afpm_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    // Configuration write port.
    input  logic              cfg_wr_en,
    input  logic [CFG_AW-1:0] cfg_addr,
    input  logic [CFG_DW-1:0] cfg_wdata,
    // Sample channel.
    input  logic              s_tvalid,
    output logic              s_tready,
    // From bit 0: accel_x 16, accel_y 16, gyro_x 16, gyro_y 16, gyro_z 16,
    // collective 8, roll_setpoint 9, pitch_setpoint 9, then 6 zero bits.
    input  logic [IN_W-1:0]   s_tdata,
    // Result channel.
    output logic              m_tvalid,
    input  logic              m_tready,
    // From bit 0: motor1_drive 12, motor2_drive 12, motor3_drive 12, motor4_drive 12,
    // roll_estimate 17, pitch_estimate 17, yaw_estimate 17, then 5 zero bits.
    output logic [OUT_W-1:0]  m_tdata
);

    // Commands flow from the sequencer to the datapath; status flows back.
    cmd_t cmd;
    sts_t sts;

    // The sequencer owns the sample handshake and the step order.
    afpm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // The datapath holds the registers, the multiplier and the output register.
    afpm_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule
